[src/gctb_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the gradient colour table builder
package gctb_pkg;

    // colour channels and packed entries
    localparam int CH_W  = 8;
    localparam int N_CH  = 4;
    localparam int COL_W = CH_W * N_CH;

    // interpolation weight, 256 stands for one
    localparam int K_W = 9;
    localparam logic [K_W-1:0] K_ONE = 9'd256;

    // divider step counter
    localparam int KCNT_W = 4;

    // stop offset, signed q2.16 in 18 bits (sign bit counted)
    localparam int OFF_W    = 18;
    localparam int OFF_FRAC = 16;

    // opacity register
    localparam int OPA_W = 9;
    localparam logic [OPA_W-1:0] OPA_RST = 9'd256;

    // request kinds carried in tuser bit 0
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // input tdata layout
    localparam int IN_TDATA_W = 64;
    localparam int OFF_LSB    = 0;
    localparam int RED_LSB    = 18;
    localparam int GREEN_LSB  = 26;
    localparam int BLUE_LSB   = 34;
    localparam int ALPHA_LSB  = 42;
    localparam int INDEX_LSB  = 50;
    localparam int INDEX_W    = 8;

    // input tuser layout
    localparam int IN_TUSER_W = 2;
    localparam int USER_MODE  = 0;
    localparam int USER_NEW   = 1;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[src/gctb_div.sv]
`timescale 1ns / 1ps
// restoring divider that works out 256 / d one quotient bit per cycle
module gctb_div
    import gctb_pkg::*;
#(
    parameter int DW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DW-1:0]   i_divisor,
    output t_div_stat       o_stat,
    output logic [K_W-1:0]  o_quo,
    output logic [DW-1:0]   o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [KCNT_W-1:0] r_cnt;
    logic [DW-1:0]     r_div;
    logic [DW-1:0]     r_rem;
    logic [K_W-1:0]    r_quo;

    logic [DW:0]       trial;
    logic              ge;
    logic [DW:0]       diff;

    // one restoring step: bring down the next dividend bit and try to subtract
    always_comb begin
        trial = {r_rem, r_quo[K_W-1]};
        ge    = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    // step control, dividend bits shift out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_quo  <= K_ONE;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_quo <= {r_quo[K_W-2:0], ge};
                if (r_cnt == KCNT_W'(K_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule

[src/gctb_blend.sv]
`timescale 1ns / 1ps
// four-lane linear blend of two packed colours by a weight in 1/256 steps
module gctb_blend
    import gctb_pkg::*;
(
    input  logic [COL_W-1:0] i_base,
    input  logic [COL_W-1:0] i_end,
    input  logic [K_W-1:0]   i_k,
    output logic [COL_W-1:0] o_colour
);

    genvar g;

    // per channel: (b*256 + (e-b)*k) >> 8, never negative for k up to one
    for (g = 0; g < N_CH; g++) begin : g_lane
        logic signed [CH_W:0]         ch_diff;
        logic signed [CH_W+K_W+1:0]   ch_prod;
        logic signed [CH_W+K_W+1:0]   ch_sum;

        always_comb begin
            ch_diff = $signed({1'b0, i_end[g*CH_W +: CH_W]})
                    - $signed({1'b0, i_base[g*CH_W +: CH_W]});
            ch_prod = (CH_W+K_W+2)'(ch_diff * $signed({1'b0, i_k}));
            ch_sum  = $signed((CH_W+K_W+2)'({i_base[g*CH_W +: CH_W], 8'd0})) + ch_prod;
        end

        assign o_colour[g*CH_W +: CH_W] = ch_sum[CH_W+7:8];
    end

endmodule

[src/gradient_colour_table_builder.sv]
`timescale 1ns / 1ps
// Gradient colour table builder. Colour stops come in one request at a time and are
// interpolated into a TABLE_ENTRIES-entry RGBA table held in a memory with one write and
// one registered read port; read requests return an entry with alpha scaled by the
// opacity register. After reset a clearing pass writes every table entry, and no request
// is taken until it ends. A read passes through the memory read register, then alpha
// scaling into the output register, once that register is free. A stop load first maps
// its offset to an index, which is all a stop that opens a list needs; any other stop
// then writes one table entry per cycle (leading fill, segment, trailing fill) through
// the one write port of the table, and a rising segment first waits for the shared
// divider to set up its interpolation step. The input is not ready meanwhile,
// but a finished read result may wait in the output register while loads go on.
module gradient_colour_table_builder
    import gctb_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // opacity register write
    input  logic                  i_cfg_we,
    input  logic [OPA_W-1:0]      i_cfg_wdata,
    // request side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // offset[17:0], red[25:18], green[33:26], blue[41:34], stop_alpha[49:42],
    // index[57:50], zero fill[63:58]
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // mode[0], new_list[1]
    input  logic [IN_TUSER_W-1:0] s_axis_tuser,
    // last_stop
    input  logic                  s_axis_tlast,
    // result side
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
    output logic [COL_W-1:0]      m_axis_tdata
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int RW = IW + 2;
    localparam int WW = IW + 4;
    localparam int PW = IW + OFF_W - 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_OUT,
        S_CALC,
        S_DECIDE,
        S_FILL_LO,
        S_SEG,
        S_DIV,
        S_INTERP,
        S_TAIL,
        S_FILL_HI,
        S_FINISH
    } t_state;

    // wrap an 8-bit read index into the table by conditional subtraction
    function automatic logic [IW-1:0] wrap_index(input logic [INDEX_W-1:0] v);
        logic [WW-1:0] acc;
        int            j;
        acc = WW'(v);
        for (j = 3; j >= 0; j--) begin
            if (acc >= (WW'(TABLE_ENTRIES) << j)) begin
                acc = acc - (WW'(TABLE_ENTRIES) << j);
            end
        end
        return acc[IW-1:0];
    endfunction

    // sequencer registers
    t_state             r_state,     n_state;
    logic [IW-1:0]      r_cnt,       n_cnt;
    logic               r_have_prev, n_have_prev;
    logic               r_first_seg, n_first_seg;
    logic [IW-1:0]      r_prev_idx,  n_prev_idx;
    logic [COL_W-1:0]   r_prev_col,  n_prev_col;
    logic [OFF_W-1:0]   r_offset,    n_offset;
    logic [COL_W-1:0]   r_colour,    n_colour;
    logic               r_new,       n_new;
    logic               r_last,      n_last;
    logic [IW-1:0]      r_idx,       n_idx;
    logic [RW-1:0]      r_r,         n_r;
    logic [K_W-1:0]     r_q,         n_q;
    logic               r_out_valid, n_out_valid;
    logic [COL_W-1:0]   r_out_data,  n_out_data;
    logic [OPA_W-1:0]   r_opacity;
    logic [COL_W-1:0]   r_rd_data;

    // table memory
    logic [COL_W-1:0]   mem [TABLE_ENTRIES];

    logic               s_acc;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [COL_W-1:0]   wr_data;

    logic [IW-1:0]      seg_d;
    logic [RW-1:0]      seg_2d;
    logic [RW-1:0]      r_sum;
    logic               r_wrap;
    logic [K_W:0]       q_sum;
    logic               div_start;
    t_div_stat          div_stat;
    logic [K_W-1:0]     div_quo;
    logic [IW-1:0]      div_rem;
    logic [COL_W-1:0]   blend_col;

    logic [PW-1:0]      idx_prod;
    logic [IW:0]        idx_wide;
    logic [CH_W+OPA_W-1:0] alpha_prod;
    logic [OPA_W-1:0]   alpha_sh;
    logic [CH_W-1:0]    alpha_sat;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // shared divider sets up the step of each rising segment
    gctb_div #(
        .DW (IW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (seg_d),
        .o_stat    (div_stat),
        .o_quo     (div_quo),
        .o_rem     (div_rem)
    );

    gctb_blend u_blend (
        .i_base   (r_prev_col),
        .i_end    (r_colour),
        .i_k      (r_q),
        .o_colour (blend_col)
    );

    // offset to index: (entries-1) * offset >> 16, negative to zero, clamped to the top
    always_comb begin
        idx_prod = PW'(TABLE_ENTRIES - 1) * PW'(r_offset[OFF_W-2:0]);
        idx_wide = idx_prod[PW-1:OFF_FRAC];
    end

    // segment length and the running remainder of the weight step
    always_comb begin
        seg_d  = r_idx - r_prev_idx;
        seg_2d = RW'({seg_d, 1'b0});
        r_sum  = r_r + RW'({div_rem, 1'b0});
        r_wrap = (r_sum >= seg_2d);
        q_sum  = {1'b0, r_q} + {1'b0, div_quo} + (K_W+1)'(r_wrap);
    end

    // alpha scaling with saturation
    always_comb begin
        alpha_prod = (CH_W+OPA_W)'(r_rd_data[3*CH_W +: CH_W]) * (CH_W+OPA_W)'(r_opacity);
        alpha_sh   = alpha_prod[CH_W+OPA_W-1:CH_W];
        alpha_sat  = (alpha_sh > OPA_W'(255)) ? 8'd255 : alpha_sh[CH_W-1:0];
    end

    assign rd_addr = wrap_index(s_axis_tdata[INDEX_LSB +: INDEX_W]);

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_have_prev = r_have_prev;
        n_first_seg = r_first_seg;
        n_prev_idx  = r_prev_idx;
        n_prev_col  = r_prev_col;
        n_offset    = r_offset;
        n_colour    = r_colour;
        n_new       = r_new;
        n_last      = r_last;
        n_idx       = r_idx;
        n_r         = r_r;
        n_q         = r_q;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_cnt;
        wr_data     = r_colour;
        div_start   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    if (s_axis_tuser[USER_MODE] == MODE_READ) begin
                        rd_en   = 1'b1;
                        n_state = S_RD_OUT;
                    end else begin
                        n_offset = s_axis_tdata[OFF_LSB +: OFF_W];
                        n_colour = {s_axis_tdata[ALPHA_LSB +: CH_W],
                                    s_axis_tdata[BLUE_LSB +: CH_W],
                                    s_axis_tdata[GREEN_LSB +: CH_W],
                                    s_axis_tdata[RED_LSB +: CH_W]};
                        n_new    = s_axis_tuser[USER_NEW];
                        n_last   = s_axis_tlast;
                        n_state  = S_CALC;
                    end
                end
            end
            S_RD_OUT: begin
                // hold the read until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {alpha_sat, r_rd_data[0 +: 3*CH_W]};
                    n_state     = S_IDLE;
                end
            end
            S_CALC: begin
                if (r_offset[OFF_W-1]) begin
                    n_idx = '0;
                end else if (idx_wide > (IW+1)'(TABLE_ENTRIES - 1)) begin
                    n_idx = LAST_IDX;
                end else begin
                    n_idx = idx_wide[IW-1:0];
                end
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_new || !r_have_prev) begin
                    // stop opens a list: only held
                    n_prev_idx  = r_idx;
                    n_prev_col  = r_colour;
                    n_have_prev = !r_last;
                    n_first_seg = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_first_seg && (r_prev_idx != '0)) begin
                    n_cnt   = '0;
                    n_state = S_FILL_LO;
                end else begin
                    n_state = S_SEG;
                end
            end
            S_FILL_LO: begin
                wr_en   = 1'b1;
                wr_data = r_prev_col;
                if (r_cnt == r_prev_idx - 1'b1) begin
                    n_state = S_SEG;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SEG: begin
                priority if (r_idx == r_prev_idx) begin
                    // zero-length segment keeps the start colour
                    wr_en   = 1'b1;
                    wr_addr = r_prev_idx;
                    wr_data = r_prev_col;
                    n_state = S_TAIL;
                end else if (r_idx > r_prev_idx) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_cnt   = r_prev_idx;
                    n_r     = RW'(seg_d);
                    n_q     = '0;
                    n_state = S_INTERP;
                end
            end
            S_INTERP: begin
                // one entry per cycle, weight advanced by quotient and remainder
                wr_en   = 1'b1;
                wr_data = blend_col;
                n_r     = r_wrap ? (r_sum - seg_2d) : r_sum;
                n_q     = q_sum[K_W-1:0];
                if (r_cnt == r_idx) begin
                    n_state = S_TAIL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_TAIL: begin
                if (r_last) begin
                    n_cnt   = r_idx;
                    n_state = S_FILL_HI;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FILL_HI: begin
                wr_en   = 1'b1;
                wr_data = r_colour;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_FINISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FINISH: begin
                n_prev_idx  = r_idx;
                n_prev_col  = r_colour;
                n_first_seg = 1'b0;
                n_have_prev = !r_last;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_have_prev <= 1'b0;
            r_first_seg <= 1'b0;
            r_prev_idx  <= '0;
            r_out_valid <= 1'b0;
            r_opacity   <= OPA_RST;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_have_prev <= n_have_prev;
            r_first_seg <= n_first_seg;
            r_prev_idx  <= n_prev_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_opacity <= i_cfg_wdata;
            end
        end
        r_prev_col <= n_prev_col;
        r_offset   <= n_offset;
        r_colour   <= n_colour;
        r_new      <= n_new;
        r_last     <= n_last;
        r_idx      <= n_idx;
        r_r        <= n_r;
        r_q        <= n_q;
        r_out_data <= n_out_data;
    end

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // writes stay inside the table
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_addr <= LAST_IDX))
        else $error("table write beyond last entry");

    // interpolation weight never passes one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INTERP) |-> (r_q <= K_ONE))
        else $error("interpolation weight above one");

    // running remainder stays below twice the segment length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INTERP) |-> ((r_r < seg_2d) && !div_stat.busy))
        else $error("weight step remainder out of range");

    // a result only appears after a read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_RD_OUT))
        else $error("result without a read request");

endmodule

[tb/sv/gradient_colour_table_builder_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the gradient colour table builder: stop lists and table reads
module gradient_colour_table_builder_tb;
    import gctb_pkg::*;

    localparam int TBL_DEPTH     = 256;
    localparam int SETTLE_CYCLES = 1000;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int RAND_PER_PHASE = 270;

    // opacity of the first three random phases, sender idling and receiver stalling of each
    localparam int OPA_SET  [4] = '{511, 0, 256, 0};
    localparam int IDLE_SET [4] = '{0, 55, 0, 28};
    localparam int STALL_SET[4] = '{0, 0, 55, 28};

    // one request toward the block
    typedef struct {
        logic                    mode;
        logic                    new_list;
        logic                    last_stop;
        logic signed [OFF_W-1:0] offset;
        logic [COL_W-1:0]        colour;     // alpha, blue, green, red from msb down
        logic [INDEX_W-1:0]      index;
        logic                    sync;       // hold until all reads have returned
    } t_table_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [OPA_W-1:0]      i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // offset, red, green, blue, stop_alpha, index, zero fill
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    // mode, new_list
    logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // red_out, green_out, blue_out, alpha_out
    logic [COL_W-1:0]      m_axis_tdata;

    gradient_colour_table_builder #(
        .TABLE_ENTRIES(TBL_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // pending requests, expected read entries, run state
    t_table_req       req_q[$];
    t_table_req       cur_req;
    logic [COL_W-1:0] want_entry_q[$];
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               fault_cnt = 0;
    int               read_cnt = 0;
    int               stall_cycles = 0;

    // shadow of the gradient table and stop list tracking
    logic [COL_W-1:0] grad_tbl [TBL_DEPTH];
    logic [7:0]       held_idx = '0;
    logic [COL_W-1:0] held_col = '0;
    logic             held_valid = 1'b0;
    logic             first_seg = 1'b0;
    logic [OPA_W-1:0] opacity_q = OPA_RST;

    initial begin
        for (int i = 0; i < TBL_DEPTH; i++) grad_tbl[i] = '0;
    end

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // update the shadow table for one accepted request, queue the entry a read returns
    task automatic model_request(input t_table_req rq);
        int               pos, i1, i2, seg_len, weight, alpha, bc, ec;
        logic [COL_W-1:0] ent, mix;
        if (rq.mode == MODE_READ) begin
            ent = grad_tbl[rq.index];
            alpha = (int'(ent[31:24]) * int'(opacity_q)) >> 8;
            if (alpha > 255) alpha = 255;
            want_entry_q.push_back({alpha[7:0], ent[23:0]});
            return;
        end
        // offset to table position, negative clamps low, overrange clamps high
        if (rq.offset[OFF_W-1]) begin
            pos = 0;
        end else begin
            pos = ((TBL_DEPTH - 1) * int'(rq.offset)) >> OFF_FRAC;
            if (pos > TBL_DEPTH - 1) pos = TBL_DEPTH - 1;
        end
        // start of a list only becomes the held stop
        if (rq.new_list || !held_valid) begin
            held_idx = pos[7:0];
            held_col = rq.colour;
            held_valid = !rq.last_stop;
            first_seg = 1'b1;
            return;
        end
        i1 = held_idx;
        i2 = pos;
        if (first_seg) begin
            for (int i = 0; i < i1; i++) grad_tbl[i] = held_col;
        end
        if (i1 == i2) begin
            grad_tbl[i1] = held_col;
        end else if (i1 < i2) begin
            seg_len = i2 - i1;
            for (int i = i1; i <= i2; i++) begin
                weight = (512 * (i - i1) + seg_len) / (2 * seg_len);
                for (int sh = 0; sh < COL_W; sh += CH_W) begin
                    bc = held_col[sh +: CH_W];
                    ec = rq.colour[sh +: CH_W];
                    mix[sh +: CH_W] = 8'((bc * (256 - weight) + ec * weight) >> 8);
                end
                grad_tbl[i] = mix;
            end
        end
        if (rq.last_stop) begin
            for (int i = i2; i < TBL_DEPTH; i++) grad_tbl[i] = rq.colour;
        end
        held_idx = pos[7:0];
        held_col = rq.colour;
        first_seg = 1'b0;
        held_valid = !rq.last_stop;
    endtask

    // request builders, unused fields get random content
    task automatic queue_stop(input logic nl, input logic lst, input int off,
                              input logic [COL_W-1:0] col);
        t_table_req rq;
        rq.mode = MODE_LOAD;
        rq.new_list = nl;
        rq.last_stop = lst;
        rq.offset = off[OFF_W-1:0];
        rq.colour = col;
        rq.index = 8'($urandom());
        rq.sync = ($urandom_range(39) == 0);
        req_q.push_back(rq);
    endtask

    task automatic queue_read(input logic [INDEX_W-1:0] idx);
        t_table_req rq;
        rq.mode = MODE_READ;
        rq.new_list = 1'($urandom());
        rq.last_stop = 1'($urandom());
        rq.offset = OFF_W'($urandom());
        rq.colour = $urandom();
        rq.index = idx;
        rq.sync = ($urandom_range(39) == 0);
        req_q.push_back(rq);
    endtask

    // random traffic: mostly well formed stop lists and read bursts, some noise
    task automatic gen_random(input int n_items);
        int target, kind, n_stops, off, o, step;
        logic nl, lst;
        target = req_q.size() + n_items;
        while (req_q.size() < target) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                n_stops = $urandom_range(1, 5);
                off = $urandom_range(0, 30000);
                for (int s = 0; s < n_stops; s++) begin
                    nl = (s == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
                    lst = (s == n_stops - 1) ? ($urandom_range(9) != 0) : 1'b0;
                    o = ($urandom_range(15) == 0) ? int'($urandom_range(0, 262143)) : off;
                    queue_stop(nl, lst, o, $urandom());
                    case ($urandom_range(9))
                        0: step = 0;
                        1: step = -int'($urandom_range(1, 20000));
                        default: step = $urandom_range(1, 40000);
                    endcase
                    off = off + step;
                    if (off < 0) off = 0;
                    if (off > 131071) off = 131071;
                end
            end else if (kind < 92) begin
                repeat ($urandom_range(1, 8)) queue_read(8'($urandom()));
            end else if ($urandom_range(1) == 0) begin
                queue_stop(1'($urandom()), 1'($urandom()), $urandom_range(0, 262143),
                           $urandom());
            end else begin
                queue_read(8'($urandom()));
            end
        end
    endtask

    // wait for the block to drain, then let any trailing load finish
    task automatic wait_idle();
        while (req_q.size() != 0 || s_axis_tvalid || want_entry_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_opacity(input logic [OPA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        opacity_q = val;
    endtask

    task automatic log_fault(input string msg);
        if (fault_cnt < 10) $display("%t: %s", $realtime, msg);
        fault_cnt++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                model_request(cur_req);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (req_q.size() != 0 && !(req_q[0].sync && want_entry_q.size() != 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = req_q.pop_front();
                    s_axis_tdata <= {{(IN_TDATA_W - INDEX_LSB - INDEX_W){1'b0}},
                                     cur_req.index, cur_req.colour, cur_req.offset};
                    s_axis_tuser <= {cur_req.new_list, cur_req.mode};
                    s_axis_tlast <= cur_req.last_stop;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        logic [COL_W-1:0] want;
        logic             bad;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                read_cnt++;
                if (want_entry_q.size() == 0) begin
                    log_fault($sformatf("read result %0d with no read pending: %08h",
                                        read_cnt, m_axis_tdata));
                end else begin
                    want = want_entry_q.pop_front();
                    bad = 1'b0;
                    for (int ch = 0; ch < N_CH; ch++)
                        if (want[ch*CH_W +: CH_W] !== m_axis_tdata[ch*CH_W +: CH_W]) bad = 1'b1;
                    if (bad)
                        log_fault($sformatf({"read result %0d mismatch: expected r=%02h g=%02h ",
                            "b=%02h a=%02h, got r=%02h g=%02h b=%02h a=%02h"}, read_cnt,
                            want[7:0], want[15:8], want[23:16], want[31:24],
                            m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                            m_axis_tdata[31:24]));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_MAX) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // reset, directed stop lists, then random phases with different opacity and idling
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reads of the cleared table
        queue_read(8'd0);
        queue_read(8'd255);
        // full ramp from zero to one
        queue_stop(1'b1, 1'b0, 0, 32'h10FF00FF);
        queue_stop(1'b0, 1'b1, 65536, 32'hFF00FF00);
        queue_read(8'd0);
        queue_read(8'd1);
        queue_read(8'd128);
        // most negative start, largest offset, then a descending last stop
        queue_stop(1'b1, 1'b0, -131072, 32'h00000000);
        queue_stop(1'b0, 1'b0, 131071, 32'hFFFFFFFF);
        queue_stop(1'b0, 1'b1, 32768, 32'h80402010);
        queue_read(8'd64);
        queue_read(8'd200);
        // equal indices, then a rising last segment
        queue_stop(1'b1, 1'b0, 32768, 32'h11223344);
        queue_stop(1'b0, 1'b0, 32768, 32'hAABBCCDD);
        queue_stop(1'b0, 1'b1, 49152, 32'h01FE7F80);
        queue_read(8'd10);
        queue_read(8'd127);
        // lone last stop, then a stop with no list open starts one
        queue_stop(1'b1, 1'b1, 16384, 32'hDEADBEEF);
        queue_stop(1'b0, 1'b0, 0, 32'h00FF0000);
        queue_stop(1'b0, 1'b1, 65535, 32'hFF0000FF);
        queue_read(8'd255);
        req_q[req_q.size()-1].sync = 1'b1;
        queue_read(8'd100);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            write_opacity((ph == 3) ? OPA_W'($urandom_range(1, 510)) : OPA_W'(OPA_SET[ph]));
            send_idle_pct = IDLE_SET[ph];
            recv_stall_pct = STALL_SET[ph];
            gen_random(RAND_PER_PHASE);
            wait_idle();
        end

        if (want_entry_q.size() != 0) log_fault("reads left without a result");
        if (fault_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
